// File: hdl/pinhole_primary_ray_direction_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pinhole primary ray direction block
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_PRIMARY_RAY_DIRECTION_MACROS_SVH
`define PINHOLE_PRIMARY_RAY_DIRECTION_MACROS_SVH

// same-cycle implication
`define PPRD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pprd_pkg.sv
// ----------------------------------------------------------------------------
// pprd_pkg
// Types, constants and width helpers shared by the ray direction pipeline.
// ----------------------------------------------------------------------------
package pprd_pkg;

  // default parameter values
  localparam int COORD_BITS_DEF    = 12;
  localparam int SUBPIXEL_BITS_DEF = 8;
  localparam int COMP_BITS_DEF     = 16;

  // configuration register widths
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int BASIS_W    = 48;
  localparam int VD_W       = 24;
  localparam int PS_W       = 16;
  localparam int RES_W      = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASIS_U,
    REG_BASIS_V,
    REG_BASIS_W,
    REG_VIEW_DIST,
    REG_PIXEL_SIZE,
    REG_HORIZ_RES,
    REG_VERT_RES
  } cfg_reg_t;

  // reset values
  localparam logic [BASIS_W-1:0] BASIS_U_RST   = 48'd16384;
  localparam logic [BASIS_W-1:0] BASIS_V_RST   = 48'd1073741824;
  localparam logic [BASIS_W-1:0] BASIS_W_RST   = 48'd70368744177664;
  localparam logic [VD_W-1:0]    VIEW_DIST_RST = 24'd128000;
  localparam logic [PS_W-1:0]    PIXEL_SIZE_RST = 16'd256;
  localparam logic [RES_W-1:0]   HORIZ_RES_RST = 12'd640;
  localparam logic [RES_W-1:0]   VERT_RES_RST  = 12'd480;

  // the largest normalized magnitude sits in [2^29, 2^30)
  localparam int NORM_MSB   = 29;
  localparam int MN_W       = NORM_MSB + 1;
  localparam int SQ_W       = 2 * MN_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int LEN_W      = SQRT_STEPS;

  // control bits traveling with each transaction
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } ctl_t;

  // width of the raw direction components (wraps modulo 2^64 beyond that)
  function automatic int mag_width(int coord_bits, int sub_bits, int comp_bits);
    int cb;
    int a_w;
    int p_w;
    int w1;
    int w2;
    int c_w;
    cb  = (coord_bits > RES_W) ? coord_bits : RES_W;
    a_w = cb + sub_bits + 2;
    p_w = a_w + PS_W + 1;
    w1  = p_w + comp_bits + 1;
    w2  = VD_W + 1 + comp_bits + sub_bits;
    c_w = ((w1 > w2) ? w1 : w2) + 1;
    return (c_w > 64) ? 64 : c_w;
  endfunction

endpackage

// File: hdl/pprd_in_if.sv
// ----------------------------------------------------------------------------
// pprd_in_if
// Sample channel: pixel coordinates and subpixel offset.
// ----------------------------------------------------------------------------
interface pprd_in_if #(
  parameter int COORD_BITS    = 12,
  parameter int SUBPIXEL_BITS = 8
);
  logic                     valid;
  logic                     ready;
  logic [COORD_BITS-1:0]    pixel_row;
  logic [COORD_BITS-1:0]    pixel_col;
  logic [SUBPIXEL_BITS-1:0] sub_x;
  logic [SUBPIXEL_BITS-1:0] sub_y;

  modport source (output valid, pixel_row, pixel_col, sub_x, sub_y, input ready);
  modport sink   (input valid, pixel_row, pixel_col, sub_x, sub_y, output ready);
endinterface

// File: hdl/pprd_out_if.sv
// ----------------------------------------------------------------------------
// pprd_out_if
// Result channel: unit ray direction and zero-length flag.
// ----------------------------------------------------------------------------
interface pprd_out_if #(
  parameter int COMP_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [COMP_BITS-1:0] dir_x;
  logic signed [COMP_BITS-1:0] dir_y;
  logic signed [COMP_BITS-1:0] dir_z;
  logic                        degenerate;

  modport source (output valid, dir_x, dir_y, dir_z, degenerate, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, degenerate, output ready);
endinterface

// File: hdl/pprd_front.sv
// ----------------------------------------------------------------------------
// pprd_front
// View-plane mapping and basis projection: five stages to signed magnitudes.
// ----------------------------------------------------------------------------
module pprd_front #(
  parameter int COORD_BITS    = 12,
  parameter int SUBPIXEL_BITS = 8,
  parameter int COMP_BITS     = 16,
  parameter int C_W           = 57
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [COORD_BITS-1:0]          pixel_row,
  input  logic [COORD_BITS-1:0]          pixel_col,
  input  logic [SUBPIXEL_BITS-1:0]       sub_x,
  input  logic [SUBPIXEL_BITS-1:0]       sub_y,
  input  logic [3*COMP_BITS-1:0]         basis_u,
  input  logic [3*COMP_BITS-1:0]         basis_v,
  input  logic [3*COMP_BITS-1:0]         basis_w,
  input  logic [pprd_pkg::VD_W-1:0]      view_distance,
  input  logic [pprd_pkg::PS_W-1:0]      pixel_size,
  input  logic [pprd_pkg::RES_W-1:0]     horizontal_res,
  input  logic [pprd_pkg::RES_W-1:0]     vertical_res,
  output pprd_pkg::ctl_t                 ctl_o,
  output logic [C_W-1:0]                 mag_o [3]
);
  import pprd_pkg::*;

  localparam int CB    = (COORD_BITS > RES_W) ? COORD_BITS : RES_W;
  localparam int A_W   = CB + SUBPIXEL_BITS + 2;
  localparam int P_W   = A_W + PS_W + 1;
  localparam int PR_W  = P_W + COMP_BITS;
  localparam int WD_W  = VD_W + 1 + COMP_BITS;

  logic [4:0] v;

  logic signed [A_W-1:0]  a0, a1;
  logic signed [P_W-1:0]  p0, p1;
  logic signed [PR_W-1:0] pu [3];
  logic signed [PR_W-1:0] pv [3];
  logic signed [WD_W-1:0] wd [3];
  logic signed [C_W-1:0]  c  [3];
  logic [2:0]             neg;
  logic [C_W-1:0]         mag [3];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  // stage 1: offset from image center in subpixel units
  always_ff @(posedge clk) begin
    if (en) begin
      a0 <= $signed(A_W'({pixel_col, sub_x}) -
                    A_W'({horizontal_res, {(SUBPIXEL_BITS-1){1'b0}}}));
      a1 <= $signed(A_W'({pixel_row, sub_y}) -
                    A_W'({vertical_res, {(SUBPIXEL_BITS-1){1'b0}}}));
    end
  end

  // stage 2: scale by pixel size
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= $signed({1'b0, pixel_size}) * a0;
      p1 <= $signed({1'b0, pixel_size}) * a1;
    end
  end

  // stage 3: per-axis products with the camera basis
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pu[k] <= p0 * $signed(basis_u[k*COMP_BITS +: COMP_BITS]);
        pv[k] <= p1 * $signed(basis_v[k*COMP_BITS +: COMP_BITS]);
        wd[k] <= $signed({1'b0, view_distance}) *
                 $signed(basis_w[k*COMP_BITS +: COMP_BITS]);
      end
    end
  end

  // stage 4: p0*u + p1*v - d*w, aligned to a common scale
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c[k] <= C_W'(pu[k]) + C_W'(pv[k]) - (C_W'(wd[k]) << SUBPIXEL_BITS);
      end
    end
  end

  // stage 5: sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg[k] <= c[k][C_W-1];
        mag[k] <= c[k][C_W-1] ? C_W'(-c[k]) : C_W'(c[k]);
      end
    end
  end

  assign ctl_o.valid = v[4];
  assign ctl_o.degen = 1'b0;
  assign ctl_o.neg   = neg;
  assign mag_o       = mag;

endmodule

// File: hdl/pprd_norm.sv
// ----------------------------------------------------------------------------
// pprd_norm
// Block normalization of the three magnitudes and sum of squares.
// ----------------------------------------------------------------------------
module pprd_norm #(
  parameter int C_W = 57
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  pprd_pkg::ctl_t             ctl_i,
  input  logic [C_W-1:0]             mag_i [3],
  output pprd_pkg::ctl_t             ctl_o,
  output logic [pprd_pkg::MN_W-1:0]  mn_o [3],
  output logic [pprd_pkg::SUM_W-1:0] sum_o
);
  import pprd_pkg::*;

  localparam int POS_W = $clog2(C_W);

  ctl_t             c1, c2, c3, c4, c5;
  logic [C_W-1:0]   m1 [3];
  logic [C_W-1:0]   m2 [3];
  logic [C_W-1:0]   orw;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] sh;
  logic             right;
  logic [MN_W-1:0]  mn3 [3];
  logic [MN_W-1:0]  mn4 [3];
  logic [MN_W-1:0]  mn5 [3];
  logic [SQ_W-1:0]  sq [3];
  logic [SUM_W-1:0] sum;

  // control through the five stages
  always_ff @(posedge clk) begin
    if (en) begin
      c1.neg   <= ctl_i.neg;
      c1.degen <= 1'b0;
      c2.neg   <= c1.neg;
      c2.degen <= (orw == '0);
      c3.neg   <= c2.neg;
      c3.degen <= c2.degen;
      c4.neg   <= c3.neg;
      c4.degen <= c3.degen;
      c5.neg   <= c4.neg;
      c5.degen <= c4.degen;
    end
    if (rst) begin
      c1.valid <= 1'b0;
      c2.valid <= 1'b0;
      c3.valid <= 1'b0;
      c4.valid <= 1'b0;
      c5.valid <= 1'b0;
    end else if (en) begin
      c1.valid <= ctl_i.valid;
      c2.valid <= c1.valid;
      c3.valid <= c2.valid;
      c4.valid <= c3.valid;
      c5.valid <= c4.valid;
    end
  end

  // leading one of the largest magnitude equals that of the OR
  always_comb begin
    pos = '0;
    for (int i = 0; i < C_W; i++) begin
      if (orw[i]) begin
        pos = POS_W'(i);
      end
    end
  end

  // stage 1: OR of magnitudes; stage 2: shift amount; stage 3: shift
  always_ff @(posedge clk) begin
    if (en) begin
      orw <= mag_i[0] | mag_i[1] | mag_i[2];
      m1  <= mag_i;
      m2  <= m1;
      if (pos >= POS_W'(NORM_MSB)) begin
        right <= 1'b1;
        sh    <= pos - POS_W'(NORM_MSB);
      end else begin
        right <= 1'b0;
        sh    <= POS_W'(NORM_MSB) - pos;
      end
      for (int k = 0; k < 3; k++) begin
        mn3[k] <= right ? MN_W'(m2[k] >> sh) : MN_W'(m2[k] << sh);
      end
    end
  end

  // stage 4: squares; stage 5: sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq[k] <= mn3[k] * mn3[k];
      end
      mn4 <= mn3;
      sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      mn5 <= mn4;
    end
  end

  assign ctl_o = c5;
  assign mn_o  = mn5;
  assign sum_o = sum;

endmodule

// File: hdl/pprd_sqrt.sv
// ----------------------------------------------------------------------------
// pprd_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pprd_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  pprd_pkg::ctl_t             ctl_i,
  input  logic [pprd_pkg::MN_W-1:0]  mn_i [3],
  input  logic [pprd_pkg::SUM_W-1:0] sum_i,
  output pprd_pkg::ctl_t             ctl_o,
  output logic [pprd_pkg::MN_W-1:0]  mn_o [3],
  output logic [pprd_pkg::LEN_W-1:0] len_o
);
  import pprd_pkg::*;

  localparam int ACC_W = SUM_W + 1;

  ctl_t             cs [SQRT_STEPS+1];
  logic [MN_W-1:0]  ms [SQRT_STEPS+1][3];
  logic [ACC_W-1:0] xs [SQRT_STEPS+1];
  logic [ACC_W-1:0] rs [SQRT_STEPS+1];

  assign cs[0] = ctl_i;
  assign ms[0] = mn_i;
  assign xs[0] = ACC_W'(sum_i);
  assign rs[0] = '0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (SUM_W - 2 - 2*i);
    logic [ACC_W-1:0] t;

    assign t = rs[i] + BIT;

    // one root bit: subtract the trial value when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        cs[i+1].degen <= cs[i].degen;
        cs[i+1].neg   <= cs[i].neg;
        ms[i+1]       <= ms[i];
        if (xs[i] >= t) begin
          xs[i+1] <= xs[i] - t;
          rs[i+1] <= (rs[i] >> 1) + BIT;
        end else begin
          xs[i+1] <= xs[i];
          rs[i+1] <= rs[i] >> 1;
        end
      end
      if (rst) begin
        cs[i+1].valid <= 1'b0;
      end else if (en) begin
        cs[i+1].valid <= cs[i].valid;
      end
    end
  end

  assign ctl_o = cs[SQRT_STEPS];
  assign mn_o  = ms[SQRT_STEPS];
  assign len_o = LEN_W'(rs[SQRT_STEPS]);

endmodule

// File: hdl/pprd_div.sv
// ----------------------------------------------------------------------------
// pprd_div
// Three-lane restoring divider: rounded magnitude over length.
// ----------------------------------------------------------------------------
module pprd_div #(
  parameter int COMP_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  pprd_pkg::ctl_t             ctl_i,
  input  logic [pprd_pkg::MN_W-1:0]  mn_i [3],
  input  logic [pprd_pkg::LEN_W-1:0] len_i,
  output pprd_pkg::ctl_t             ctl_o,
  output logic [COMP_BITS-2:0]       q_o [3]
);
  import pprd_pkg::*;

  localparam int F     = COMP_BITS - 2;
  localparam int Q_W   = F + 1;
  localparam int N_W   = MN_W + F + 1;
  localparam int D_W   = LEN_W + Q_W;
  localparam int CMP_W = ((N_W > D_W) ? N_W : D_W) + 1;

  ctl_t             cs [Q_W+1];
  logic [LEN_W-1:0] ls [Q_W+1];
  logic [CMP_W-1:0] rem [Q_W+1][3];
  logic [Q_W-1:0]   qs [Q_W+1][3];

  // entry stage: numerator with half the divisor added for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      cs[0].degen <= ctl_i.degen;
      cs[0].neg   <= ctl_i.neg;
      ls[0]       <= len_i;
      for (int k = 0; k < 3; k++) begin
        rem[0][k] <= CMP_W'(N_W'({mn_i[k], {F{1'b0}}}) + N_W'(len_i >> 1));
        qs[0][k]  <= '0;
      end
    end
    if (rst) begin
      cs[0].valid <= 1'b0;
    end else if (en) begin
      cs[0].valid <= ctl_i.valid;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < Q_W; j++) begin : g_step
    logic [CMP_W-1:0] d;

    assign d = CMP_W'(ls[j]) << (Q_W - 1 - j);

    always_ff @(posedge clk) begin
      if (en) begin
        cs[j+1].degen <= cs[j].degen;
        cs[j+1].neg   <= cs[j].neg;
        ls[j+1]       <= ls[j];
        for (int k = 0; k < 3; k++) begin
          if (rem[j][k] >= d) begin
            rem[j+1][k] <= rem[j][k] - d;
            qs[j+1][k]  <= {qs[j][k][Q_W-2:0], 1'b1};
          end else begin
            rem[j+1][k] <= rem[j][k];
            qs[j+1][k]  <= {qs[j][k][Q_W-2:0], 1'b0};
          end
        end
      end
      if (rst) begin
        cs[j+1].valid <= 1'b0;
      end else if (en) begin
        cs[j+1].valid <= cs[j].valid;
      end
    end
  end

  assign ctl_o = cs[Q_W];
  assign q_o   = qs[Q_W];

endmodule

// File: hdl/pinhole_primary_ray_direction.sv
// ----------------------------------------------------------------------------
// pinhole_primary_ray_direction
// Pinhole camera primary ray: pixel sample in, unit direction vector out.
// ----------------------------------------------------------------------------
// Accepts one sample per clock while the skid entry is empty and returns one
// result per sample, in order. Stages: view-plane mapping and basis
// projection, block normalization and sum of squares, the square root with
// its root-bit stages, the divider with its numerator stage and quotient-bit
// stages, and the output register. The pipeline advances as a whole; a skid
// entry behind the output register lets it keep taking samples while the
// consumer stalls, until a result has to wait there. A zero-length direction
// gives a zero vector with degenerate set. The user must write configuration
// through cfg_we / cfg_index / cfg_data only while no transaction is in
// flight; the block itself does not enforce it.
module pinhole_primary_ray_direction #(
  parameter int COORD_BITS    = pprd_pkg::COORD_BITS_DEF,
  parameter int SUBPIXEL_BITS = pprd_pkg::SUBPIXEL_BITS_DEF,
  parameter int COMP_BITS     = pprd_pkg::COMP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pprd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pprd_pkg::CFG_DATA_W-1:0] cfg_data,
  pprd_in_if.sink                        in_ch,
  pprd_out_if.source                     out_ch
);
  import pprd_pkg::*;

  localparam int C_W   = mag_width(COORD_BITS, SUBPIXEL_BITS, COMP_BITS);
  localparam int BAS_W = 3 * COMP_BITS;
  localparam int Q_W   = COMP_BITS - 1;

  // configuration registers
  logic [BASIS_W-1:0] basis_u, basis_v, basis_w;
  logic [VD_W-1:0]    view_distance;
  logic [PS_W-1:0]    pixel_size;
  logic [RES_W-1:0]   horizontal_res, vertical_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_u        <= BASIS_U_RST;
      basis_v        <= BASIS_V_RST;
      basis_w        <= BASIS_W_RST;
      view_distance  <= VIEW_DIST_RST;
      pixel_size     <= PIXEL_SIZE_RST;
      horizontal_res <= HORIZ_RES_RST;
      vertical_res   <= VERT_RES_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASIS_U:    basis_u        <= BASIS_W'(cfg_data);
        REG_BASIS_V:    basis_v        <= BASIS_W'(cfg_data);
        REG_BASIS_W:    basis_w        <= BASIS_W'(cfg_data);
        REG_VIEW_DIST:  view_distance  <= VD_W'(cfg_data);
        REG_PIXEL_SIZE: pixel_size     <= PS_W'(cfg_data);
        REG_HORIZ_RES:  horizontal_res <= RES_W'(cfg_data);
        REG_VERT_RES:   vertical_res   <= RES_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // pipeline advance: held only while the skid entry is occupied
  logic skid_v;
  logic en;

  assign en          = ~skid_v;
  assign in_ch.ready = en;

  ctl_t           f_ctl, n_ctl, s_ctl, d_ctl;
  logic [C_W-1:0] f_mag [3];
  logic [MN_W-1:0] n_mn [3];
  logic [MN_W-1:0] s_mn [3];
  logic [SUM_W-1:0] n_sum;
  logic [LEN_W-1:0] s_len;
  logic [Q_W-1:0]   d_q [3];

  pprd_front #(
    .COORD_BITS    (COORD_BITS),
    .SUBPIXEL_BITS (SUBPIXEL_BITS),
    .COMP_BITS     (COMP_BITS),
    .C_W           (C_W)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_ch.valid),
    .pixel_row      (in_ch.pixel_row),
    .pixel_col      (in_ch.pixel_col),
    .sub_x          (in_ch.sub_x),
    .sub_y          (in_ch.sub_y),
    .basis_u        (BAS_W'(basis_u)),
    .basis_v        (BAS_W'(basis_v)),
    .basis_w        (BAS_W'(basis_w)),
    .view_distance  (view_distance),
    .pixel_size     (pixel_size),
    .horizontal_res (horizontal_res),
    .vertical_res   (vertical_res),
    .ctl_o          (f_ctl),
    .mag_o          (f_mag)
  );

  pprd_norm #(
    .C_W (C_W)
  ) u_norm (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .ctl_i (f_ctl),
    .mag_i (f_mag),
    .ctl_o (n_ctl),
    .mn_o  (n_mn),
    .sum_o (n_sum)
  );

  pprd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .ctl_i (n_ctl),
    .mn_i  (n_mn),
    .sum_i (n_sum),
    .ctl_o (s_ctl),
    .mn_o  (s_mn),
    .len_o (s_len)
  );

  pprd_div #(
    .COMP_BITS (COMP_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .ctl_i (s_ctl),
    .mn_i  (s_mn),
    .len_i (s_len),
    .ctl_o (d_ctl),
    .q_o   (d_q)
  );

  // apply signs; zero-length vector reads as zero
  logic signed [COMP_BITS-1:0] res [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (d_ctl.degen) begin
        res[k] = '0;
      end else if (d_ctl.neg[k]) begin
        res[k] = -$signed({1'b0, d_q[k]});
      end else begin
        res[k] = $signed({1'b0, d_q[k]});
      end
    end
  end

  // output register and skid entry
  logic                        out_v;
  logic signed [COMP_BITS-1:0] out_dir [3];
  logic                        out_degen;
  logic signed [COMP_BITS-1:0] skid_dir [3];
  logic                        skid_degen;
  logic                        take;

  assign take = ~out_v | out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (take) begin
      out_v  <= skid_v | d_ctl.valid;
      skid_v <= 1'b0;
    end else if (en && d_ctl.valid) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_v) begin
        out_dir   <= skid_dir;
        out_degen <= skid_degen;
      end else begin
        out_dir   <= res;
        out_degen <= d_ctl.degen;
      end
    end else if (en) begin
      skid_dir   <= res;
      skid_degen <= d_ctl.degen;
    end
  end

  assign out_ch.valid      = out_v;
  assign out_ch.dir_x      = out_dir[0];
  assign out_ch.dir_y      = out_dir[1];
  assign out_ch.dir_z      = out_dir[2];
  assign out_ch.degenerate = out_degen;

endmodule

// File: hdl/pprd_checker.sv
// ----------------------------------------------------------------------------
// pprd_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "pinhole_primary_ray_direction_macros.svh"

module pprd_checker #(
  parameter int COMP_BITS = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [COMP_BITS-1:0] dir_x,
  input logic signed [COMP_BITS-1:0] dir_y,
  input logic signed [COMP_BITS-1:0] dir_z,
  input logic                        degenerate
);
  localparam logic signed [COMP_BITS-1:0] LIM  = COMP_BITS'(1) <<< (COMP_BITS - 2);
  localparam logic signed [COMP_BITS-1:0] NLIM = -LIM;

  // zero-length flag comes with a zero vector
  `PPRD_ASSERT_IMPL(a_degen_zero, clk, rst, out_valid && degenerate, dir_x == 0 && dir_y == 0 && dir_z == 0, "degenerate result with nonzero direction")

  // a real direction never collapses to zero
  `PPRD_ASSERT_IMPL(a_dir_nonzero, clk, rst, out_valid && !degenerate, dir_x != 0 || dir_y != 0 || dir_z != 0, "unit direction is all zero")

  // components stay within unit magnitude
  `PPRD_ASSERT_IMPL(a_dir_range, clk, rst, out_valid, dir_x <= LIM && dir_x >= NLIM && dir_y <= LIM && dir_y >= NLIM && dir_z <= LIM && dir_z >= NLIM, "direction component beyond unit range")

  // stalled transaction holds
  `PPRD_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(dir_x) && $stable(dir_y) && $stable(dir_z) && $stable(degenerate), "stalled result changed")

endmodule

bind pinhole_primary_ray_direction pprd_checker #(
  .COMP_BITS (COMP_BITS)
) u_pprd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .dir_x      (out_ch.dir_x),
  .dir_y      (out_ch.dir_y),
  .dir_z      (out_ch.dir_z),
  .degenerate (out_ch.degenerate)
);
